[sv/slev_pkg.sv]
// ----------------------------------------------------------------------------
// slev_pkg
// Types and constants shared by the line editor and its testbench.
// ----------------------------------------------------------------------------
package slev_pkg;

  localparam int RESULT_LIMIT = 32;
  localparam int RUN_W        = $clog2(RESULT_LIMIT + 1);

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_DEL = 8'h7F;
  localparam logic [7:0] CHAR_ESC = 8'h1B;
  localparam logic [7:0] CHAR_LBR = 8'h5B;
  localparam logic [7:0] CHAR_UP  = 8'h41;
  localparam logic [7:0] CHAR_DN  = 8'h42;

  typedef enum logic [1:0] {
    KIND_ECHO     = 2'd0,
    KIND_COMMAND  = 2'd1,
    KIND_REDRAW   = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ESC_NONE    = 2'd0,
    ESC_SEEN    = 2'd1,
    ESC_BRACKET = 2'd2
  } esc_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SRC,
    ST_LEN,
    ST_COPY,
    ST_EMIT
  } state_e;

endpackage

[sv/slev_ram.sv]
// ----------------------------------------------------------------------------
// slev_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module slev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/serial_line_editor_with_history_top.sv]
// An accepted typed byte, DEL or CR moves the block to its emit state, which loads the result
// words into the output register, one result word per cycle while the output is not stalled.
// Recall (ESC [ A / ESC [ B): bit-serial offset reduction, slot lookup, a copy of the line through
// the single byte-RAM port pair when it is not empty and comes from another slot, then the redraw words.
// A new byte is accepted once the last result word of the previous one is loaded.
// Reset clears the slot length valid bits at once; no clearing pass, byte RAM is left as is.
// ----------------------------------------------------------------------------
// serial_line_editor_with_history_top
// Terminal line editor keeping typed lines in a ring of history slots.
// ----------------------------------------------------------------------------
module serial_line_editor_with_history_top #(
  parameter int LINE_CAPACITY = 32,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o
);

  localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
  localparam int IDX_W  = $clog2(LINE_CAPACITY);
  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int MOD_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int BYTE_DEPTH = HISTORY_DEPTH * (2 ** IDX_W);
  localparam int RUN_W  = slev_pkg::RUN_W;

  slev_pkg::state_e     state_q, state_d;
  slev_pkg::esc_phase_e esc_q, esc_d;
  slev_pkg::kind_e      run_kind_q, run_kind_d;
  slev_pkg::kind_e      out_kind_q, out_kind_d;

  logic [LEN_W-1:0]         line_count_q, line_count_d;
  logic [SLOT_W-1:0]        cur_q, cur_d;
  logic [7:0]               offset_q, offset_d;
  logic                     ring_full_q, ring_full_d;
  logic [HISTORY_DEPTH-1:0] len_valid_q, len_valid_d;
  logic [RUN_W-1:0]         run_left_q, run_left_d;
  logic                     out_valid_q, out_valid_d;
  logic [MOD_W-1:0]         mod_q, mod_d;
  logic [MOD_W-1:0]         rem_q, rem_d;
  logic [7:0]               dvd_q, dvd_d;
  logic [2:0]               div_cnt_q, div_cnt_d;
  logic [SLOT_W-1:0]        src_q, src_d;
  logic [LEN_W-1:0]         rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]         wr_idx_q, wr_idx_d;
  logic                     wr_pend_q, wr_pend_d;

  logic                     len_we;
  logic [SLOT_W-1:0]        len_waddr, len_raddr;
  logic [LEN_W-1:0]         len_wdata, len_rdata;
  logic                     byte_we;
  logic [SLOT_W+IDX_W-1:0]  byte_waddr, byte_raddr;
  logic [7:0]               byte_wdata, byte_rdata;

  logic                     accept;
  logic                     out_free;
  logic [LEN_W-1:0]         run_n;
  logic                     run_load;
  logic [LEN_W-1:0]         lc_dec;
  logic [7:0]               offset_new;
  logic [MOD_W:0]           div_t;
  logic [MOD_W-1:0]         ring_d;
  logic [MOD_W:0]           ring_s;
  logic [LEN_W-1:0]         len_rd;
  logic                     copy_issue;

  slev_ram #(
    .WIDTH (LEN_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  slev_ram #(
    .WIDTH (8),
    .DEPTH (BYTE_DEPTH)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (byte_wdata),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != slev_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    esc_d        = esc_q;
    run_kind_d   = run_kind_q;
    out_kind_d   = out_kind_q;
    out_valid_d  = out_valid_q && out_stall_i;
    line_count_d = line_count_q;
    cur_d        = cur_q;
    offset_d     = offset_q;
    ring_full_d  = ring_full_q;
    len_valid_d  = len_valid_q;
    run_left_d   = run_left_q;
    mod_d        = mod_q;
    rem_d        = rem_q;
    dvd_d        = dvd_q;
    div_cnt_d    = div_cnt_q;
    src_d        = src_q;
    rd_idx_d     = rd_idx_q;
    wr_idx_d     = wr_idx_q;
    wr_pend_d    = 1'b0;

    len_we       = 1'b0;
    len_waddr    = cur_q;
    len_wdata    = line_count_q;
    len_raddr    = src_q;
    byte_we      = 1'b0;
    byte_waddr   = {cur_q, line_count_q[IDX_W-1:0]};
    byte_wdata   = rx_byte_i;
    byte_raddr   = {src_q, rd_idx_q[IDX_W-1:0]};

    run_n        = '0;
    run_load     = 1'b0;
    lc_dec       = (line_count_q == '0) ? '0 : line_count_q - LEN_W'(1);
    offset_new   = offset_q + ((rx_byte_i == slev_pkg::CHAR_UP) ? 8'hFF : 8'h01);
    div_t        = {rem_q, dvd_q[7]};
    ring_d       = '0;
    ring_s       = '0;
    len_rd       = '0;
    copy_issue   = 1'b0;

    unique case (state_q)
      slev_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (esc_q)
            slev_pkg::ESC_SEEN: begin
              esc_d = (rx_byte_i == slev_pkg::CHAR_LBR) ? slev_pkg::ESC_BRACKET
                                                        : slev_pkg::ESC_NONE;
            end
            slev_pkg::ESC_BRACKET: begin
              esc_d = slev_pkg::ESC_NONE;
              if (rx_byte_i == slev_pkg::CHAR_UP || rx_byte_i == slev_pkg::CHAR_DN) begin
                offset_d  = offset_new;
                mod_d     = ring_full_q ? MOD_W'(HISTORY_DEPTH) : MOD_W'(cur_q) + MOD_W'(1);
                dvd_d     = offset_new[7] ? (8'd0 - offset_new) : offset_new;
                rem_d     = '0;
                div_cnt_d = '0;
                state_d   = slev_pkg::ST_DIV;
              end
            end
            default: begin
              esc_d = slev_pkg::ESC_NONE;
              if (rx_byte_i == slev_pkg::CHAR_CR) begin
                len_we       = 1'b1;
                len_wdata    = line_count_q;
                len_valid_d[cur_q] = 1'b1;
                run_n        = line_count_q;
                run_kind_d   = slev_pkg::KIND_COMMAND;
                run_load     = 1'b1;
                line_count_d = '0;
                offset_d     = '0;
                if (cur_q == SLOT_W'(HISTORY_DEPTH - 1)) begin
                  cur_d       = '0;
                  ring_full_d = 1'b1;
                  len_valid_d[0] = 1'b0;
                end else begin
                  cur_d = cur_q + SLOT_W'(1);
                  len_valid_d[cur_q + SLOT_W'(1)] = 1'b0;
                end
              end else if (rx_byte_i == slev_pkg::CHAR_DEL) begin
                line_count_d = lc_dec;
                len_we       = 1'b1;
                len_wdata    = lc_dec;
                len_valid_d[cur_q] = 1'b1;
                run_n        = lc_dec;
                run_kind_d   = slev_pkg::KIND_REDRAW;
                run_load     = 1'b1;
              end else if (rx_byte_i == slev_pkg::CHAR_ESC) begin
                esc_d = slev_pkg::ESC_SEEN;
              end else if (line_count_q >= LEN_W'(LINE_CAPACITY)) begin
                line_count_d = '0;
                len_we       = 1'b1;
                len_wdata    = '0;
                len_valid_d[cur_q] = 1'b1;
                run_n        = LEN_W'(1);
                run_kind_d   = slev_pkg::KIND_TOO_LONG;
                run_load     = 1'b1;
              end else begin
                byte_we      = 1'b1;
                line_count_d = line_count_q + LEN_W'(1);
                len_we       = 1'b1;
                len_wdata    = line_count_q + LEN_W'(1);
                len_valid_d[cur_q] = 1'b1;
                run_n        = LEN_W'(1);
                run_kind_d   = slev_pkg::KIND_ECHO;
                run_load     = 1'b1;
              end
            end
          endcase
        end
      end
      slev_pkg::ST_DIV: begin
        if (div_t >= {1'b0, mod_q}) begin
          div_t = div_t - {1'b0, mod_q};
        end
        rem_d     = div_t[MOD_W-1:0];
        dvd_d     = {dvd_q[6:0], 1'b0};
        div_cnt_d = div_cnt_q + 3'd1;
        if (div_cnt_q == 3'd7) begin
          state_d = slev_pkg::ST_SRC;
        end
      end
      slev_pkg::ST_SRC: begin
        ring_d = (offset_q[7] && rem_q != '0) ? mod_q - rem_q : rem_q;
        ring_s = {1'b0, ring_d} + (MOD_W + 1)'(cur_q);
        if (ring_s >= {1'b0, mod_q}) begin
          ring_s = ring_s - {1'b0, mod_q};
        end
        src_d     = ring_s[SLOT_W-1:0];
        len_raddr = ring_s[SLOT_W-1:0];
        state_d   = slev_pkg::ST_LEN;
      end
      slev_pkg::ST_LEN: begin
        len_rd = len_valid_q[src_q] ? len_rdata : '0;
        if (len_rd > LEN_W'(LINE_CAPACITY)) begin
          len_rd = LEN_W'(LINE_CAPACITY);
        end
        line_count_d = len_rd;
        len_we       = 1'b1;
        len_wdata    = len_rd;
        len_valid_d[cur_q] = 1'b1;
        run_n        = len_rd;
        run_kind_d   = slev_pkg::KIND_REDRAW;
        run_load     = 1'b1;
        rd_idx_d     = '0;
        if (src_q != cur_q && len_rd != '0) begin
          state_d = slev_pkg::ST_COPY;
        end else begin
          state_d = slev_pkg::ST_EMIT;
        end
      end
      slev_pkg::ST_COPY: begin
        copy_issue = (rd_idx_q < line_count_q);
        if (wr_pend_q) begin
          byte_we    = 1'b1;
          byte_waddr = {cur_q, wr_idx_q};
          byte_wdata = byte_rdata;
        end
        if (copy_issue) begin
          rd_idx_d  = rd_idx_q + LEN_W'(1);
          wr_idx_d  = rd_idx_q[IDX_W-1:0];
          wr_pend_d = 1'b1;
        end else if (!wr_pend_q) begin
          state_d = slev_pkg::ST_EMIT;
        end
      end
      slev_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = run_kind_q;
          run_left_d  = run_left_q - RUN_W'(1);
          if (run_left_q == RUN_W'(1)) begin
            state_d = slev_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = slev_pkg::ST_IDLE;
      end
    endcase

    if (run_load) begin
      if (run_n == '0) begin
        run_left_d = RUN_W'(1);
      end else if (int'(run_n) > slev_pkg::RESULT_LIMIT) begin
        run_left_d = RUN_W'(slev_pkg::RESULT_LIMIT);
      end else begin
        run_left_d = RUN_W'(run_n);
      end
      if (state_q == slev_pkg::ST_IDLE) begin
        state_d = slev_pkg::ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= slev_pkg::ST_IDLE;
      esc_q        <= slev_pkg::ESC_NONE;
      run_kind_q   <= slev_pkg::KIND_ECHO;
      out_kind_q   <= slev_pkg::KIND_ECHO;
      out_valid_q  <= 1'b0;
      line_count_q <= '0;
      cur_q        <= '0;
      offset_q     <= '0;
      ring_full_q  <= 1'b0;
      len_valid_q  <= '0;
      run_left_q   <= '0;
      mod_q        <= '0;
      rem_q        <= '0;
      dvd_q        <= '0;
      div_cnt_q    <= '0;
      src_q        <= '0;
      rd_idx_q     <= '0;
      wr_idx_q     <= '0;
      wr_pend_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      esc_q        <= esc_d;
      run_kind_q   <= run_kind_d;
      out_kind_q   <= out_kind_d;
      out_valid_q  <= out_valid_d;
      line_count_q <= line_count_d;
      cur_q        <= cur_d;
      offset_q     <= offset_d;
      ring_full_q  <= ring_full_d;
      len_valid_q  <= len_valid_d;
      run_left_q   <= run_left_d;
      mod_q        <= mod_d;
      rem_q        <= rem_d;
      dvd_q        <= dvd_d;
      div_cnt_q    <= div_cnt_d;
      src_q        <= src_d;
      rd_idx_q     <= rd_idx_d;
      wr_idx_q     <= wr_idx_d;
      wr_pend_q    <= wr_pend_d;
    end
  end

  a_line_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_count_q <= LEN_W'(LINE_CAPACITY))
    else $error("line count above capacity");

  a_copy_other_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == slev_pkg::ST_COPY |-> src_q != cur_q)
    else $error("copy into its own slot");

  a_emit_has_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == slev_pkg::ST_EMIT |-> run_left_q != '0)
    else $error("emit state with empty run");

  a_recall_keeps_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == slev_pkg::ST_DIV |=> $stable(cur_q))
    else $error("slot moved during recall");

  a_src_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == slev_pkg::ST_LEN |-> int'(src_q) < HISTORY_DEPTH)
    else $error("recall source outside ring");

endmodule

[tb/sv/line_editor_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_editor_checker
// Watches both channels of the line editor. Every accepted byte updates a
// copy of the editor state and queues the result kinds it must produce.
// Every accepted result word is compared with the oldest queued kind.
// ----------------------------------------------------------------------------
module line_editor_checker #(
  parameter int LINE_CAPACITY = 32,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] kind_i,
  output int         mismatch_count_o,
  output int         words_pending_o
);

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);

  logic [LEN_W-1:0]     slot_len [HISTORY_DEPTH];
  logic [LEN_W-1:0]     line_len;
  logic [SLOT_W-1:0]    cur_slot;
  logic [7:0]           recall_ofs;
  logic                 ring_wrapped;
  slev_pkg::esc_phase_e esc_phase;

  slev_pkg::kind_e expected_kinds[$];
  slev_pkg::kind_e want;
  int              mismatches;

  task automatic queue_run(input slev_pkg::kind_e k, input int n);
    if (n < 1) n = 1;
    if (n > slev_pkg::RESULT_LIMIT) n = slev_pkg::RESULT_LIMIT;
    repeat (n) expected_kinds.push_back(k);
  endtask

  task automatic recall_line(input logic [7:0] step);
    int modulus;
    int ofs;
    int src;
    int len;
    modulus    = ring_wrapped ? HISTORY_DEPTH : int'(cur_slot) + 1;
    recall_ofs = recall_ofs + step;
    ofs        = int'($signed(recall_ofs));
    src        = ofs % modulus;
    if (src < 0) src += modulus;
    src += int'(cur_slot);
    if (src >= modulus) src -= modulus;
    len = int'(slot_len[src]);
    if (len > LINE_CAPACITY) len = LINE_CAPACITY;
    line_len           = LEN_W'(len);
    slot_len[cur_slot] = LEN_W'(len);
    queue_run(slev_pkg::KIND_REDRAW, len);
  endtask

  task automatic predict_byte(input logic [7:0] b);
    int run_len;
    case (esc_phase)
      slev_pkg::ESC_SEEN: begin
        esc_phase = (b == slev_pkg::CHAR_LBR) ? slev_pkg::ESC_BRACKET : slev_pkg::ESC_NONE;
      end
      slev_pkg::ESC_BRACKET: begin
        esc_phase = slev_pkg::ESC_NONE;
        if (b == slev_pkg::CHAR_UP) recall_line(8'hFF);
        else if (b == slev_pkg::CHAR_DN) recall_line(8'h01);
      end
      default: begin
        esc_phase = slev_pkg::ESC_NONE;
        if (b == slev_pkg::CHAR_CR) begin
          run_len            = int'(line_len);
          slot_len[cur_slot] = line_len;
          line_len           = '0;
          recall_ofs         = '0;
          cur_slot           = SLOT_W'((int'(cur_slot) + 1) % HISTORY_DEPTH);
          if (cur_slot == '0) ring_wrapped = 1'b1;
          slot_len[cur_slot] = '0;
          queue_run(slev_pkg::KIND_COMMAND, run_len);
        end else if (b == slev_pkg::CHAR_DEL) begin
          if (line_len != '0) line_len = line_len - LEN_W'(1);
          slot_len[cur_slot] = line_len;
          queue_run(slev_pkg::KIND_REDRAW, int'(line_len));
        end else if (b == slev_pkg::CHAR_ESC) begin
          esc_phase = slev_pkg::ESC_SEEN;
        end else if (int'(line_len) >= LINE_CAPACITY) begin
          line_len           = '0;
          slot_len[cur_slot] = '0;
          expected_kinds.push_back(slev_pkg::KIND_TOO_LONG);
        end else begin
          line_len           = line_len + LEN_W'(1);
          slot_len[cur_slot] = line_len;
          expected_kinds.push_back(slev_pkg::KIND_ECHO);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < HISTORY_DEPTH; s++) slot_len[s] = '0;
      line_len     = '0;
      cur_slot     = '0;
      recall_ofs   = '0;
      ring_wrapped = 1'b0;
      esc_phase    = slev_pkg::ESC_NONE;
      expected_kinds.delete();
      mismatches   = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_byte(rx_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_kinds.size() == 0) begin
          $error("kind: no word expected, actual %0d", kind_i);
          mismatches++;
        end else begin
          want = expected_kinds.pop_front();
          if (kind_i !== want) begin
            $error("kind: expected %0d, actual %0d", want, kind_i);
            mismatches++;
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    words_pending_o  <= expected_kinds.size();
  end

endmodule

[tb/sv/serial_line_editor_with_history_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_editor_with_history_top_tb
// Feeds the line editor typed lines, edits, history recalls, broken escape
// sequences, overlong lines and random bytes, with random gaps on the input
// and random stalls on the output. A checker beside the block predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module serial_line_editor_with_history_top_tb;

  localparam int LINE_CAPACITY = 32;
  localparam int HISTORY_DEPTH = 8;
  localparam int RANDOM_BYTES  = 100;
  localparam int DRAIN_CYCLES  = 200;
  localparam int CYCLE_LIMIT   = 1_000_000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] kind_o;

  int mismatch_count;
  int words_pending;
  int cycle_count = 0;
  int bytes_sent  = 0;
  bit calm        = 1'b0;

  serial_line_editor_with_history_top #(
    .LINE_CAPACITY(LINE_CAPACITY),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o)
  );

  line_editor_checker #(
    .LINE_CAPACITY(LINE_CAPACITY),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_i          (kind_o),
    .mismatch_count_o(mismatch_count),
    .words_pending_o (words_pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 8);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!calm && ($urandom_range(99) < 8)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic type_line(input int n);
    repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7E)));
  endtask

  task automatic send_recall(input logic [7:0] dir);
    send_byte(slev_pkg::CHAR_ESC);
    send_byte(slev_pkg::CHAR_LBR);
    send_byte(dir);
  endtask

  initial begin
    int pick;
    int random_end;
    int calm_from;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // line with extreme byte values, then an empty command
    send_byte("h");
    send_byte("i");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(slev_pkg::CHAR_CR);
    send_byte(slev_pkg::CHAR_CR);
    // delete on empty line, delete down to empty
    send_byte(slev_pkg::CHAR_DEL);
    send_byte("x");
    send_byte(slev_pkg::CHAR_DEL);
    // recall older twice, newer once, then unused keys and broken escapes
    send_recall(slev_pkg::CHAR_UP);
    send_recall(slev_pkg::CHAR_UP);
    send_recall(slev_pkg::CHAR_DN);
    send_recall("C");
    send_byte(slev_pkg::CHAR_ESC);
    send_byte("Q");
    send_byte(slev_pkg::CHAR_ESC);
    send_byte(slev_pkg::CHAR_ESC);
    send_byte(slev_pkg::CHAR_CR);

    random_end = bytes_sent + RANDOM_BYTES;
    calm_from  = bytes_sent + 20;
    while (bytes_sent < random_end) begin
      calm <= (bytes_sent >= calm_from) && (bytes_sent < calm_from + 40);
      pick = $urandom_range(99);
      if (pick < 35) begin
        type_line($urandom_range(12));
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) send_byte(slev_pkg::CHAR_DEL);
        send_byte(slev_pkg::CHAR_CR);
      end else if (pick < 50) begin
        repeat ($urandom_range(1, 3))
          send_recall($urandom_range(1) ? slev_pkg::CHAR_UP : slev_pkg::CHAR_DN);
        type_line($urandom_range(3));
        if ($urandom_range(4) != 0) send_byte(slev_pkg::CHAR_CR);
      end else if (pick < 60) begin
        type_line($urandom_range(28, 36));
        send_byte($urandom_range(1) ? slev_pkg::CHAR_CR : slev_pkg::CHAR_DEL);
      end else if (pick < 70) begin
        send_byte(slev_pkg::CHAR_ESC);
        if ($urandom_range(1)) send_byte(slev_pkg::CHAR_LBR);
        send_byte(8'($urandom_range(255)));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) send_byte(slev_pkg::CHAR_DEL);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end
    end
    calm <= 1'b0;

    // walk the recall offset past its signed limit
    type_line(3);
    send_byte(slev_pkg::CHAR_CR);
    repeat (130) send_recall(slev_pkg::CHAR_DN);
    send_byte(slev_pkg::CHAR_CR);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
